[hdl/tpsd_pkg.sv]
`default_nettype none

package tpsd_pkg;

  localparam int PALETTE_DEPTH = 256;
  localparam int PAL_AW = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;

  localparam logic [31:0] OPAQUE_BLACK = 32'hFF00_0000;

  localparam logic [1:0] MODE_MAPPED = 2'd0;
  localparam logic [1:0] MODE_TRUE   = 2'd1;
  localparam logic [1:0] MODE_GREY   = 2'd2;

  typedef enum logic [2:0] {
    CFG_COLOR_MODE     = 3'd0,
    CFG_RLE_ENABLE     = 3'd1,
    CFG_PIXEL_BYTES    = 3'd2,
    CFG_MAP_ENTRY_BITS = 3'd3,
    CFG_IMAGE_WIDTH    = 3'd4,
    CFG_IMAGE_HEIGHT   = 3'd5,
    CFG_MIRROR_COLUMNS = 3'd6,
    CFG_TOP_DOWN       = 3'd7
  } cfg_reg_e;

  // pixel format settings seen by the colour converter
  typedef struct packed {
    logic [1:0] color_mode;
    logic [2:0] pixel_bytes;
    logic [5:0] map_entry_bits;
  } tpsd_fmt_t;

  // 5-bit to 8-bit channel, rounded as (v*255+15)/31
  function automatic logic [7:0] widen5(logic [4:0] v);
    logic [2:0] f;
    f = 3'd0;
    if (v >= 5'd3)  f = 3'd1;
    if (v >= 5'd7)  f = 3'd2;
    if (v >= 5'd12) f = 3'd3;
    if (v >= 5'd16) f = 3'd4;
    if (v >= 5'd20) f = 3'd5;
    if (v >= 5'd25) f = 3'd6;
    if (v >= 5'd29) f = 3'd7;
    return {v, 3'b000} + {5'b00000, f};
  endfunction

  function automatic logic [31:0] from555(logic [15:0] v);
    return {8'hFF, widen5(v[14:10]), widen5(v[9:5]), widen5(v[4:0])};
  endfunction

endpackage

`default_nettype wire

[hdl/tpsd_in_if.sv]
`default_nettype none

interface tpsd_in_if;
  logic        valid;
  logic        ready;
  logic        cmd;
  logic [7:0]  data_byte;
  logic [7:0]  palette_index;
  logic [31:0] palette_entry;

  modport source (output valid, cmd, data_byte, palette_index, palette_entry, input ready);
  modport sink   (input valid, cmd, data_byte, palette_index, palette_entry, output ready);
endinterface

`default_nettype wire

[hdl/tpsd_out_if.sv]
`default_nettype none

interface tpsd_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] span_argb;
  logic [15:0] dest_row;
  logic [15:0] start_column;
  logic [7:0]  span_length;
  logic        image_done;

  modport source (output valid, span_argb, dest_row, start_column, span_length, image_done,
                  input ready);
  modport sink   (input valid, span_argb, dest_row, start_column, span_length, image_done,
                  output ready);
endinterface

`default_nettype wire

[hdl/tpsd_ram.sv]
`default_nettype none

module tpsd_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

`default_nettype wire

[hdl/tpsd_color.sv]
`default_nettype none

module tpsd_color import tpsd_pkg::*; (
  input  wire logic      [31:0] px_i,
  input  wire tpsd_fmt_t        fmt_i,
  input  wire logic             pal_ok_i,
  input  wire logic      [31:0] pal_raw_i,
  output logic           [31:0] argb_o
);

  logic [31:0] pal_argb;

  always_comb begin
    pal_argb = OPAQUE_BLACK;
    if (pal_ok_i) begin
      case (fmt_i.map_entry_bits)
        6'd15, 6'd16: pal_argb = from555(pal_raw_i[15:0]);
        6'd24:        pal_argb = {8'hFF, pal_raw_i[23:0]};
        6'd32:        pal_argb = pal_raw_i;
        default:      pal_argb = OPAQUE_BLACK;
      endcase
    end
  end

  always_comb begin
    argb_o = OPAQUE_BLACK;
    if (fmt_i.pixel_bytes >= 3'd1 && fmt_i.pixel_bytes <= 3'd4) begin
      case (fmt_i.color_mode)
        MODE_MAPPED: argb_o = pal_argb;
        MODE_TRUE: begin
          case (fmt_i.pixel_bytes)
            3'd2:    argb_o = from555(px_i[15:0]);
            3'd3:    argb_o = {8'hFF, px_i[23:0]};
            3'd4:    argb_o = px_i;
            default: argb_o = OPAQUE_BLACK;
          endcase
        end
        MODE_GREY: argb_o = {8'hFF, px_i[7:0], px_i[7:0], px_i[7:0]};
        default:   argb_o = OPAQUE_BLACK;
      endcase
    end
  end

endmodule

`default_nettype wire

[hdl/tga_pixel_stream_decoder.sv]
`default_nettype none
// Channel     Dir  Carries
// pix_in      in   cmd, data_byte, palette_index, palette_entry
// span_out    out  span_argb, dest_row, start_column, span_length, image_done
// cfg_*_i     in   register index and data, written when cfg_we_i is high
//
// One word accepted per cycle; a stalled output holds both stages, and pix_in.ready
// drops only when both are full. Stage 1 registers packet/position update and
// palette read; colour conversion feeds the output registers. Reset sets config
// defaults, clears stream state and palette valid bits; palette contents kept.

module tga_pixel_stream_decoder import tpsd_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [2:0]  cfg_idx_i,
  input  wire logic [15:0] cfg_data_i,
  tpsd_in_if.sink          pix_in,
  tpsd_out_if.source       span_out
);

  // configuration
  logic [1:0]  color_mode_q;
  logic        rle_enable_q;
  logic [2:0]  pixel_bytes_q;
  logic [5:0]  map_entry_bits_q;
  logic [15:0] width_q, height_q;
  logic        mirror_q, top_down_q;

  // stream state
  logic [23:0] gather_q, gather_d;
  logic [1:0]  held_q, held_d;
  logic [7:0]  pkt_left_q, pkt_left_d;
  logic        pkt_run_q, pkt_run_d;
  logic [15:0] col_q, col_d;
  logic [15:0] row_q, row_d;
  logic        finished_q, finished_d;

  logic [PALETTE_DEPTH-1:0] pal_valid_q;

  // stage 1 and output registers
  logic        s1_valid_q;
  logic [31:0] s1_px_q;
  logic        s1_pal_ok_q;
  logic [15:0] s1_row_q, s1_col_q;
  logic [7:0]  s1_len_q;
  logic        s1_done_q;
  logic        out_valid_q;
  logic [31:0] out_argb_q;
  logic [15:0] out_row_q, out_col_q;
  logic [7:0]  out_len_q;
  logic        out_done_q;

  logic        out_adv, s1_load, in_fire, pal_we, emit;
  logic        active, header, gather_more, end_row;
  logic [2:0]  bpp;
  logic [31:0] px;
  logic [15:0] room, run_len, len16, col_next, row_inc, dst_col, dst_row;
  logic [15:0] pal_idx;
  logic        pal_in_range;
  logic [PAL_AW-1:0] pal_raddr;
  logic [31:0] pal_raw, argb;
  tpsd_fmt_t   fmt;

  assign out_adv = !out_valid_q || span_out.ready;
  assign s1_load = !s1_valid_q || out_adv;
  assign pix_in.ready = s1_load;
  assign in_fire = pix_in.valid && s1_load;
  assign pal_we = in_fire && pix_in.cmd &&
                  (32'(pix_in.palette_index) < 32'(PALETTE_DEPTH));

  always_comb begin
    bpp = pixel_bytes_q;
    if (pixel_bytes_q < 3'd1) bpp = 3'd1;
    if (pixel_bytes_q > 3'd4) bpp = 3'd4;
  end

  assign active = (width_q != 16'd0) && (height_q != 16'd0) && !finished_q;
  assign header = rle_enable_q && (pkt_left_q == 8'd0);
  assign gather_more = ({1'b0, held_q} + 3'd1) < bpp;
  assign px = {8'h00, gather_q} | (32'(pix_in.data_byte) << {held_q, 3'b000});

  assign room = width_q - col_q;
  assign run_len = ({8'h00, pkt_left_q} < room) ? {8'h00, pkt_left_q} : room;
  assign len16 = (rle_enable_q && pkt_run_q) ? run_len : 16'd1;
  assign col_next = col_q + len16;
  assign end_row = col_next >= width_q;
  assign row_inc = row_q + 16'd1;
  assign dst_col = mirror_q ? (width_q - 16'd1 - col_q) : col_q;
  assign dst_row = top_down_q ? row_q : (height_q - 16'd1 - row_q);

  assign emit = in_fire && !pix_in.cmd && active && !header && !gather_more;

  always_comb begin
    gather_d   = gather_q;
    held_d     = held_q;
    pkt_left_d = pkt_left_q;
    pkt_run_d  = pkt_run_q;
    col_d      = col_q;
    row_d      = row_q;
    finished_d = finished_q;
    if (in_fire && !pix_in.cmd && active) begin
      if (header) begin
        pkt_left_d = {1'b0, pix_in.data_byte[6:0]} + 8'd1;
        pkt_run_d  = pix_in.data_byte[7];
      end else if (gather_more) begin
        gather_d = gather_q | (24'(pix_in.data_byte) << {held_q, 3'b000});
        held_d   = held_q + 2'd1;
      end else begin
        gather_d = 24'd0;
        held_d   = 2'd0;
        if (rle_enable_q && pkt_run_q) begin
          pkt_left_d = 8'd0;
        end else if (rle_enable_q) begin
          pkt_left_d = pkt_left_q - 8'd1;
        end
        col_d = col_next;
        if (end_row) begin
          col_d      = 16'd0;
          pkt_left_d = 8'd0;
          row_d      = row_inc;
          if (row_inc >= height_q) begin
            finished_d = 1'b1;
          end
        end
      end
    end
  end

  // palette index: 16-bit pixel for two-byte pixels, else first byte
  assign pal_idx = (pixel_bytes_q == 3'd2) ? px[15:0] : {8'h00, px[7:0]};
  assign pal_in_range = 32'(pal_idx) < 32'(PALETTE_DEPTH);
  assign pal_raddr = PAL_AW'(pal_idx);

  tpsd_ram #(
    .WIDTH (32),
    .DEPTH (PALETTE_DEPTH)
  ) u_palette (
    .clk_i   (clk_i),
    .we_i    (pal_we),
    .waddr_i (PAL_AW'(pix_in.palette_index)),
    .wdata_i (pix_in.palette_entry),
    .re_i    (emit),
    .raddr_i (pal_raddr),
    .rdata_o (pal_raw)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      color_mode_q     <= MODE_TRUE;
      rle_enable_q     <= 1'b0;
      pixel_bytes_q    <= 3'd3;
      map_entry_bits_q <= 6'd24;
      width_q          <= 16'd0;
      height_q         <= 16'd0;
      mirror_q         <= 1'b0;
      top_down_q       <= 1'b0;
      gather_q         <= 24'd0;
      held_q           <= 2'd0;
      pkt_left_q       <= 8'd0;
      pkt_run_q        <= 1'b0;
      col_q            <= 16'd0;
      row_q            <= 16'd0;
      finished_q       <= 1'b0;
      pal_valid_q      <= '0;
    end else begin
      if (pal_we) begin
        pal_valid_q[PAL_AW'(pix_in.palette_index)] <= 1'b1;
      end
      if (cfg_we_i) begin
        case (cfg_reg_e'(cfg_idx_i))
          CFG_COLOR_MODE:     color_mode_q     <= cfg_data_i[1:0];
          CFG_RLE_ENABLE:     rle_enable_q     <= cfg_data_i[0];
          CFG_PIXEL_BYTES:    pixel_bytes_q    <= cfg_data_i[2:0];
          CFG_MAP_ENTRY_BITS: map_entry_bits_q <= cfg_data_i[5:0];
          CFG_IMAGE_WIDTH:    width_q          <= cfg_data_i;
          CFG_IMAGE_HEIGHT:   height_q         <= cfg_data_i;
          CFG_MIRROR_COLUMNS: mirror_q         <= cfg_data_i[0];
          CFG_TOP_DOWN:       top_down_q       <= cfg_data_i[0];
          default:            color_mode_q     <= color_mode_q;
        endcase
        // any register write restarts the stream
        gather_q   <= 24'd0;
        held_q     <= 2'd0;
        pkt_left_q <= 8'd0;
        pkt_run_q  <= 1'b0;
        col_q      <= 16'd0;
        row_q      <= 16'd0;
        finished_q <= 1'b0;
      end else begin
        gather_q   <= gather_d;
        held_q     <= held_d;
        pkt_left_q <= pkt_left_d;
        pkt_run_q  <= pkt_run_d;
        col_q      <= col_d;
        row_q      <= row_d;
        finished_q <= finished_d;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s1_load) begin
        s1_valid_q <= emit;
      end
      if (out_adv) begin
        out_valid_q <= s1_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      s1_px_q     <= px;
      s1_pal_ok_q <= pal_in_range && pal_valid_q[pal_raddr];
      s1_row_q    <= dst_row;
      s1_col_q    <= dst_col;
      s1_len_q    <= len16[7:0];
      s1_done_q   <= end_row && (row_inc >= height_q);
    end
    if (out_adv && s1_valid_q) begin
      out_argb_q <= argb;
      out_row_q  <= s1_row_q;
      out_col_q  <= s1_col_q;
      out_len_q  <= s1_len_q;
      out_done_q <= s1_done_q;
    end
  end

  assign fmt = '{color_mode: color_mode_q, pixel_bytes: pixel_bytes_q,
                 map_entry_bits: map_entry_bits_q};

  tpsd_color u_color (
    .px_i      (s1_px_q),
    .fmt_i     (fmt),
    .pal_ok_i  (s1_pal_ok_q),
    .pal_raw_i (pal_raw),
    .argb_o    (argb)
  );

  assign span_out.valid        = out_valid_q;
  assign span_out.span_argb    = out_argb_q;
  assign span_out.dest_row     = out_row_q;
  assign span_out.start_column = out_col_q;
  assign span_out.span_length  = out_len_q;
  assign span_out.image_done   = out_done_q;

`ifndef SYNTHESIS
  a_s1_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && !out_adv |=> s1_valid_q)
    else $error("stage 1 word lost under stall");

  a_len_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> out_len_q != 8'd0)
    else $error("empty span presented");

  a_col_in_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    col_q == 16'd0 || col_q < width_q)
    else $error("column position beyond row end");

  a_done_wraps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    finished_q |-> col_q == 16'd0 && pkt_left_q == 8'd0)
    else $error("frame finished with row or packet open");
`endif

endmodule

`default_nettype wire

[bench/testbench.sv]
module testbench;
  import tpsd_pkg::*;

  localparam logic       CMD_PIXEL   = 1'b0;
  localparam logic       CMD_PALETTE = 1'b1;
  localparam logic [1:0] MODE_NONE   = 2'd3;
  localparam int WORD_TARGET = 1150;
  localparam int STALL_LIMIT = 2000;
  localparam int SETTLE      = 5;

  typedef struct packed {
    logic [31:0] argb;
    logic [15:0] row;
    logic [15:0] column;
    logic [7:0]  length;
    logic        done;
  } span_t;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [2:0]  cfg_idx_i;
  logic [15:0] cfg_data_i;

  tpsd_in_if  pix_in();
  tpsd_out_if span_out();

  tga_pixel_stream_decoder uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .pix_in     (pix_in),
    .span_out   (span_out)
  );

  // decoder state as the bench sees it
  logic [1:0]  fmt_mode;
  logic        fmt_rle;
  logic [2:0]  fmt_bytes;
  logic [5:0]  fmt_entry_bits;
  logic [15:0] img_w, img_h;
  logic        img_mirror, img_top_down;
  logic [31:0] pal_word [PALETTE_DEPTH];
  logic        pal_set  [PALETTE_DEPTH];
  logic [23:0] gather;
  int unsigned held;
  logic [7:0]  pkt_left;
  logic        pkt_run;
  int unsigned col_pos, row_pos;
  logic        finished;

  span_t       pending_spans[$];
  int unsigned words_taken;
  int unsigned error_count;
  int          feed_idle_pct  = 32;
  int          drain_idle_pct = 51;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) span_out.ready <= ($urandom_range(99) >= drain_idle_pct);

  task automatic report_error(input string msg);
    error_count++;
    if (error_count <= 100) $display("ERROR at %0t: %s", $time, msg);
  endtask

  function automatic logic [7:0] stretch5(input logic [4:0] v);
    int unsigned t;
    t = (int'(v) * 255 + 15) / 31;
    return t[7:0];
  endfunction

  function automatic logic [31:0] rgb555(input logic [15:0] v);
    return {8'hFF, stretch5(v[14:10]), stretch5(v[9:5]), stretch5(v[4:0])};
  endfunction

  function automatic logic [31:0] pixel_colour(input logic [31:0] px);
    logic [15:0] idx;
    logic [31:0] raw;
    idx = (fmt_bytes == 3'd2) ? px[15:0] : {8'h00, px[7:0]};
    if (fmt_bytes < 3'd1 || fmt_bytes > 3'd4) return OPAQUE_BLACK;
    case (fmt_mode)
      MODE_MAPPED: begin
        if (idx >= PALETTE_DEPTH || !pal_set[idx[PAL_AW-1:0]]) return OPAQUE_BLACK;
        raw = pal_word[idx[PAL_AW-1:0]];
        case (fmt_entry_bits)
          6'd15, 6'd16: return rgb555(raw[15:0]);
          6'd24: return {8'hFF, raw[23:0]};
          6'd32: return raw;
          default: return OPAQUE_BLACK;
        endcase
      end
      MODE_TRUE: begin
        case (fmt_bytes)
          3'd2: return rgb555(px[15:0]);
          3'd3: return {8'hFF, px[23:0]};
          3'd4: return px;
          default: return OPAQUE_BLACK;
        endcase
      end
      MODE_GREY: return {8'hFF, px[7:0], px[7:0], px[7:0]};
      default: return OPAQUE_BLACK;
    endcase
  endfunction

  task automatic restart_stream();
    gather   = '0;
    held     = 0;
    pkt_left = '0;
    pkt_run  = 1'b0;
    col_pos  = 0;
    row_pos  = 0;
    finished = 1'b0;
  endtask

  // advance the decoder by one accepted word, queueing the span it yields
  task automatic decode_word(input logic c, input logic [7:0] b, input logic [7:0] pidx,
                             input logic [31:0] pent);
    int unsigned nbytes, len, room, col, row;
    logic [31:0] px;
    span_t s;
    if (c == CMD_PALETTE) begin
      words_taken++;
      if (pidx < PALETTE_DEPTH) begin
        pal_word[pidx] = pent;
        pal_set[pidx]  = 1'b1;
      end
      return;
    end
    if (img_w == 16'd0 || img_h == 16'd0 || finished) return;
    words_taken++;
    if (fmt_rle && pkt_left == 8'd0) begin
      pkt_left = {1'b0, b[6:0]} + 8'd1;
      pkt_run  = b[7];
      return;
    end
    nbytes = 32'(fmt_bytes);
    if (nbytes < 1) nbytes = 1;
    if (nbytes > 4) nbytes = 4;
    if (held + 1 < nbytes) begin
      gather = gather | 24'(32'(b) << (8 * held));
      held++;
      return;
    end
    px     = {8'h00, gather} | (32'(b) << (8 * held));
    gather = '0;
    held   = 0;

    room = img_w - col_pos;
    if (fmt_rle && pkt_run) begin
      len      = (32'(pkt_left) < room) ? 32'(pkt_left) : room;
      pkt_left = '0;
    end else begin
      len = 1;
      if (fmt_rle) pkt_left--;
    end
    col = img_mirror ? (img_w - 1 - col_pos) : col_pos;
    row = img_top_down ? row_pos : (img_h - 1 - row_pos);

    s.done = 1'b0;
    col_pos += len;
    if (col_pos >= img_w) begin
      col_pos  = 0;
      pkt_left = '0;
      row_pos++;
      if (row_pos >= img_h) begin
        finished = 1'b1;
        s.done   = 1'b1;
      end
    end
    s.argb   = pixel_colour(px);
    s.row    = row[15:0];
    s.column = col[15:0];
    s.length = len[7:0];
    pending_spans.push_back(s);
  endtask

  task automatic send_word(input logic c, input logic [7:0] b, input logic [7:0] pidx,
                           input logic [31:0] pent);
    while ($urandom_range(99) < feed_idle_pct) begin
      pix_in.valid <= 1'b0;
      @(posedge clk_i);
    end
    pix_in.valid         <= 1'b1;
    pix_in.cmd           <= c;
    pix_in.data_byte     <= b;
    pix_in.palette_index <= pidx;
    pix_in.palette_entry <= pent;
    @(posedge clk_i);
    while (!pix_in.ready) @(posedge clk_i);
    decode_word(c, b, pidx, pent);
  endtask

  task automatic send_pixel(input logic [7:0] b);
    send_word(CMD_PIXEL, b, 8'($urandom), $urandom);
  endtask

  task automatic send_palette(input logic [7:0] idx, input logic [31:0] entry);
    send_word(CMD_PALETTE, 8'($urandom), idx, entry);
  endtask

  // only with the decoder idle; unused upper data bits carry noise
  task automatic set_reg(input cfg_reg_e which, input logic [15:0] value);
    logic [15:0] keep, data;
    pix_in.valid <= 1'b0;
    while (pending_spans.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
    case (which)
      CFG_COLOR_MODE:     keep = 16'h0003;
      CFG_PIXEL_BYTES:    keep = 16'h0007;
      CFG_MAP_ENTRY_BITS: keep = 16'h003F;
      CFG_IMAGE_WIDTH,
      CFG_IMAGE_HEIGHT:   keep = 16'hFFFF;
      default:            keep = 16'h0001;
    endcase
    data = (value & keep) | (16'($urandom) & ~keep);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= which;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (which)
      CFG_COLOR_MODE:     fmt_mode       = data[1:0];
      CFG_RLE_ENABLE:     fmt_rle        = data[0];
      CFG_PIXEL_BYTES:    fmt_bytes      = data[2:0];
      CFG_MAP_ENTRY_BITS: fmt_entry_bits = data[5:0];
      CFG_IMAGE_WIDTH:    img_w          = data;
      CFG_IMAGE_HEIGHT:   img_h          = data;
      CFG_MIRROR_COLUMNS: img_mirror     = data[0];
      default:            img_top_down   = data[0];
    endcase
    restart_stream();
  endtask

  task automatic set_format(input logic [1:0] mode, input logic rle, input logic [2:0] nbytes,
                            input logic [5:0] ebits, input logic [15:0] w,
                            input logic [15:0] h, input logic mirror, input logic top_down);
    set_reg(CFG_COLOR_MODE, 16'(mode));
    set_reg(CFG_RLE_ENABLE, 16'(rle));
    set_reg(CFG_PIXEL_BYTES, 16'(nbytes));
    set_reg(CFG_MAP_ENTRY_BITS, 16'(ebits));
    set_reg(CFG_IMAGE_WIDTH, w);
    set_reg(CFG_IMAGE_HEIGHT, h);
    set_reg(CFG_MIRROR_COLUMNS, 16'(mirror));
    set_reg(CFG_TOP_DOWN, 16'(top_down));
  endtask

  // well-formed stream byte for the current decoder state
  function automatic logic [7:0] next_stream_byte();
    logic [7:0] hdr;
    if (fmt_rle && pkt_left == 8'd0) begin
      hdr    = ($urandom_range(1) == 0) ? 8'($urandom_range(0, 7)) :
                                          8'($urandom_range(0, 127));
      hdr[7] = 1'($urandom_range(1));
      return hdr;
    end
    // keep most 16-bit palette indices in range
    if (fmt_mode == MODE_MAPPED && fmt_bytes == 3'd2 && held == 1 && $urandom_range(3) != 0)
      return 8'h00;
    return 8'($urandom);
  endfunction

  task automatic test_empty_image();
    send_pixel(8'h00);
    send_pixel(8'hFF);
    set_reg(CFG_IMAGE_WIDTH, 16'd4);
    send_pixel(8'hA5);
    set_reg(CFG_IMAGE_HEIGHT, 16'd3);
    set_reg(CFG_IMAGE_WIDTH, 16'd0);
    send_pixel(8'h5A);
  endtask

  // every slot written before any colour-mapped pixel is decoded
  task automatic test_palette_load();
    for (int i = 0; i < PALETTE_DEPTH; i++) begin
      if (i == 0) send_palette(8'(i), 32'h0000_0000);
      else if (i == PALETTE_DEPTH - 1) send_palette(8'(i), 32'hFFFF_FFFF);
      else send_palette(8'(i), $urandom);
    end
  endtask

  task automatic test_true_colour();
    set_format(MODE_TRUE, 1'b0, 3'd3, 6'd24, 16'd2, 16'd1, 1'b0, 1'b0);
    send_pixel(8'hFF); send_pixel(8'hFF); send_pixel(8'hFF);
    send_pixel(8'h00); send_pixel(8'h00); send_pixel(8'h00);
  endtask

  // run longer than the row, then raw packet cut at row end, then trailing byte
  task automatic test_row_cut();
    set_format(MODE_GREY, 1'b1, 3'd1, 6'd24, 16'd3, 16'd2, 1'b1, 1'b1);
    send_pixel(8'hFF);
    send_pixel(8'h00);
    send_pixel(8'h7F);
    send_pixel(8'hFF);
    send_pixel(8'h80);
    send_pixel(8'h01);
    send_pixel(8'h55);
  endtask

  task automatic test_unsupported();
    set_format(MODE_TRUE, 1'b0, 3'd0, 6'd24, 16'd1, 16'd1, 1'b0, 1'b0);
    send_pixel(8'h7E);
    set_reg(CFG_PIXEL_BYTES, 16'd7);
    repeat (4) send_pixel(8'($urandom));
    set_reg(CFG_PIXEL_BYTES, 16'd1);
    send_pixel(8'hC3);
    set_reg(CFG_COLOR_MODE, 16'(MODE_NONE));
    send_pixel(8'h3C);
  endtask

  task automatic test_mapped_range();
    set_format(MODE_MAPPED, 1'b0, 3'd2, 6'd15, 16'd2, 16'd1, 1'b1, 1'b0);
    send_pixel(8'h05); send_pixel(8'h01);
    send_pixel(8'hFF); send_pixel(8'h00);
  endtask

  task automatic test_random_images();
    int unsigned base, share, budget, pick, img;
    logic [15:0] w, h;
    logic [5:0]  ebits;
    logic [2:0]  nbytes;
    logic [1:0]  mode;
    base  = words_taken;
    share = (WORD_TARGET - base) / 3;
    img   = 0;
    while (words_taken < WORD_TARGET) begin
      if (words_taken < base + share) begin
        feed_idle_pct = 32; drain_idle_pct = 51;
      end else if (words_taken < base + 2 * share) begin
        feed_idle_pct = 51; drain_idle_pct = 32;
      end else begin
        feed_idle_pct = 0; drain_idle_pct = 0;
      end
      pick = $urandom_range(99);
      if (img == 0 || pick < 4) begin
        w = 16'hFFFF; h = 16'hFFFF; budget = 30;
      end else if (pick < 20) begin
        w = 16'($urandom_range(129, 300)); h = 16'($urandom_range(1, 2)); budget = 80;
      end else begin
        w = 16'($urandom_range(1, 6)); h = 16'($urandom_range(1, 4)); budget = 100;
      end
      mode = ($urandom_range(99) < 5) ? MODE_NONE : 2'($urandom_range(2));
      if ($urandom_range(99) < 8) nbytes = 3'($urandom_range(0, 7));
      else nbytes = 3'($urandom_range(1, 4));
      if ($urandom_range(99) < 15) ebits = 6'($urandom_range(0, 32));
      else begin
        case ($urandom_range(3))
          0: ebits = 6'd15;
          1: ebits = 6'd16;
          2: ebits = 6'd24;
          default: ebits = 6'd32;
        endcase
      end
      set_format(mode, 1'($urandom_range(1)), nbytes, ebits, w, h, 1'($urandom_range(1)),
                 1'($urandom_range(1)));
      while (budget > 0 && !finished) begin
        if ($urandom_range(99) < 4) send_palette(8'($urandom), $urandom);
        else begin
          send_pixel(next_stream_byte());
          budget--;
        end
      end
      if (finished && $urandom_range(1)) send_pixel(8'($urandom));
      img++;
    end
  endtask

  always @(posedge clk_i) begin : check_spans
    span_t want;
    if (rst_ni && span_out.valid && span_out.ready) begin
      if (pending_spans.size() == 0) begin
        report_error("span output with nothing expected");
      end else begin
        want = pending_spans.pop_front();
        if (span_out.span_argb !== want.argb)
          report_error($sformatf("span_argb %h, expected %h", span_out.span_argb, want.argb));
        if (span_out.dest_row !== want.row)
          report_error($sformatf("dest_row %0d, expected %0d", span_out.dest_row, want.row));
        if (span_out.start_column !== want.column)
          report_error($sformatf("start_column %0d, expected %0d", span_out.start_column,
                                 want.column));
        if (span_out.span_length !== want.length)
          report_error($sformatf("span_length %0d, expected %0d", span_out.span_length,
                                 want.length));
        if (span_out.image_done !== want.done)
          report_error($sformatf("image_done %b, expected %b", span_out.image_done, want.done));
      end
    end
  end

  // ends the run if no word moves on either side for too long
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((pix_in.valid && pix_in.ready) || (span_out.valid && span_out.ready)) quiet = 0;
      else quiet++;
    end
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    rst_ni               = 1'b0;
    cfg_we_i             = 1'b0;
    cfg_idx_i            = CFG_COLOR_MODE;
    cfg_data_i           = '0;
    pix_in.valid         = 1'b0;
    pix_in.cmd           = CMD_PIXEL;
    pix_in.data_byte     = '0;
    pix_in.palette_index = '0;
    pix_in.palette_entry = '0;
    error_count          = 0;
    words_taken          = 0;
    fmt_mode             = MODE_TRUE;
    fmt_rle              = 1'b0;
    fmt_bytes            = 3'd3;
    fmt_entry_bits       = 6'd24;
    img_w                = '0;
    img_h                = '0;
    img_mirror           = 1'b0;
    img_top_down         = 1'b0;
    for (int i = 0; i < PALETTE_DEPTH; i++) begin
      pal_word[i] = '0;
      pal_set[i]  = 1'b0;
    end
    restart_stream();
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_empty_image();
    test_palette_load();
    test_true_colour();
    test_row_cut();
    test_unsupported();
    test_mapped_range();
    test_random_images();

    pix_in.valid <= 1'b0;
    while (pending_spans.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (error_count == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

endmodule
